### hw/rtl/crcfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-16 frame parser package
// Shared constants, types and the per-byte CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package crcfp_pkg;

  localparam int unsigned MinFrameBytes = 21;
  localparam int unsigned IdBytes       = 12;

  localparam logic [8:0]  HdrEnd   = 9'd2;
  localparam logic [8:0]  AddrPos  = 9'(HdrEnd + IdBytes);
  localparam logic [8:0]  CmdPos   = AddrPos + 9'd1;
  localparam logic [8:0]  SizePos  = CmdPos + 9'd1;
  localparam logic [8:0]  PayPos   = SizePos + 9'd1;
  localparam logic [8:0]  CountMax = 9'd511;

  localparam logic [7:0]  HdrByte0 = 8'hAB;
  localparam logic [7:0]  HdrByte1 = 8'hFF;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_CRC = 2'd2
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  device_addr;
    logic [7:0]  command;
    logic [7:0]  payload_size;
    logic [31:0] uid_high;
    logic [63:0] uid_low;
    status_e     status;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/crc16_frame_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-16 frame parser unit
// Checks header, length and CRC-16/MODBUS of a byte stream frame and reports
// payload bytes and a per-frame verdict.
// ----------------------------------------------------------------------------
// A result is registered and appears in the cycle after its word is taken.
// Throughput: one input word per cycle; the CRC byte update is a single
// combinational XOR network between the frame state and the output register.
// A new word is taken while the output register is empty or its word leaves.
// Reset: asynchronous, active low; the parser starts a new frame after reset.
module crc16_frame_parser_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata,   // payload_byte, payload_index,
                                            // device_addr, command, payload_size,
                                            // uid_high, uid_low, status, zero pad
  output logic              m_axis_tuser    // [0] kind
);
  import crcfp_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_q;
  logic    out_valid_q, out_valid_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  crcfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_byte_i   (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'b000000, out_q.status, out_q.uid_low, out_q.uid_high,
                          out_q.payload_size, out_q.command, out_q.device_addr,
                          out_q.payload_index, out_q.payload_byte};

endmodule
`default_nettype wire

### hw/rtl/crcfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-16 frame parser core
// Holds the frame state and forms the result caused by each accepted byte.
// ----------------------------------------------------------------------------
module crcfp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              frame_end_i,
  output logic                   res_valid_o,
  output crcfp_pkg::result_t     res_o
);
  import crcfp_pkg::*;

  logic [8:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic        hdr_q, hdr_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  size_q, size_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [7:0]  id_q [IdBytes];
  logic [7:0]  id_d [IdBytes];

  logic [8:0]  pos;
  logic [8:0]  crc_pos;
  logic [9:0]  len;
  logic [3:0]  id_idx;
  logic        id_wr;
  logic        is_payload;
  logic [7:0]  uid [IdBytes];
  status_e     status;

  assign pos     = count_q;
  assign crc_pos = PayPos + {1'b0, size_q};
  assign len     = {1'b0, pos} + 10'd1;
  assign id_idx  = 4'(pos - HdrEnd);
  assign id_wr   = (pos >= HdrEnd) && (pos < AddrPos);

  always_comb begin
    hdr_d      = hdr_q;
    crc_d      = crc_q;
    addr_d     = addr_q;
    cmd_d      = cmd_q;
    size_d     = size_q;
    rcrc_d     = rcrc_q;
    is_payload = 1'b0;
    for (int i = 0; i < IdBytes; i++) begin
      id_d[i] = (id_wr && (id_idx == 4'(i))) ? in_byte_i : id_q[i];
    end
    if (pos == 9'd0) begin
      hdr_d = hdr_q && (in_byte_i == HdrByte0);
    end else if (pos == 9'd1) begin
      hdr_d = hdr_q && (in_byte_i == HdrByte1);
    end else if (pos < PayPos) begin
      if (pos == AddrPos) begin
        addr_d = in_byte_i;
      end else if (pos == CmdPos) begin
        cmd_d = in_byte_i;
      end else if (pos == SizePos) begin
        size_d = in_byte_i;
      end
      crc_d = crc_byte(crc_q, in_byte_i);
    end else if (pos < crc_pos) begin
      crc_d      = crc_byte(crc_q, in_byte_i);
      is_payload = 1'b1;
    end else if (pos == crc_pos) begin
      rcrc_d = {rcrc_q[15:8], in_byte_i};
    end else if (pos == crc_pos + 9'd1) begin
      rcrc_d = {in_byte_i, rcrc_q[7:0]};
    end

    if ((len < 10'(MinFrameBytes)) || !hdr_d) begin
      status = ST_LEN;
    end else if (len < ({1'b0, crc_pos} + 10'd2)) begin
      status = ST_LEN;
    end else if (crc_d != rcrc_d) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end

    // Id bytes not yet received in this frame read as zero.
    for (int i = 0; i < IdBytes; i++) begin
      uid[i] = (pos >= 9'(HdrEnd + i)) ? id_d[i] : 8'h00;
    end
  end

  always_comb begin
    res_valid_o         = in_valid_i && (frame_end_i || is_payload);
    res_o.kind          = frame_end_i ? KIND_VERDICT : KIND_PAYLOAD;
    res_o.payload_byte  = frame_end_i ? 8'h00 : in_byte_i;
    res_o.payload_index = frame_end_i ? 8'h00 : 8'(pos - PayPos);
    res_o.device_addr   = addr_d;
    res_o.command       = cmd_d;
    res_o.payload_size  = size_d;
    res_o.uid_high      = {uid[0], uid[1], uid[2], uid[3]};
    res_o.uid_low       = {uid[4], uid[5], uid[6], uid[7],
                           uid[8], uid[9], uid[10], uid[11]};
    res_o.status        = frame_end_i ? status : ST_OK;
  end

  always_comb begin
    if (frame_end_i) begin
      count_d = 9'd0;
    end else if (pos != CountMax) begin
      count_d = pos + 9'd1;
    end else begin
      count_d = pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 9'd0;
      crc_q   <= CrcInit;
      hdr_q   <= 1'b1;
      addr_q  <= 8'h00;
      cmd_q   <= 8'h00;
      size_q  <= 8'h00;
      rcrc_q  <= 16'h0000;
    end else if (in_valid_i) begin
      count_q <= count_d;
      if (frame_end_i) begin
        crc_q  <= CrcInit;
        hdr_q  <= 1'b1;
        addr_q <= 8'h00;
        cmd_q  <= 8'h00;
        size_q <= 8'h00;
        rcrc_q <= 16'h0000;
      end else begin
        crc_q  <= crc_d;
        hdr_q  <= hdr_d;
        addr_q <= addr_d;
        cmd_q  <= cmd_d;
        size_q <= size_d;
        rcrc_q <= rcrc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      id_q <= id_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/crcfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-16 frame parser checker
// Port-level properties of the frame parser unit, bound to the top level.
// ----------------------------------------------------------------------------
module crcfp_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,
  input  wire logic         s_axis_tlast,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [143:0] m_axis_tdata,
  input  wire logic         m_axis_tuser
);
  import crcfp_pkg::*;

  logic [1:0] out_status;
  assign out_status = m_axis_tdata[137:136];

  // A final word always yields a verdict in the next cycle.
  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata == s_axis_tdata)
    |=> m_axis_tvalid && (m_axis_tuser == KIND_VERDICT))
    else $error("final word did not yield a verdict");

  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD) |-> out_status == ST_OK)
    else $error("payload word carries a nonzero status");

  a_verdict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_VERDICT) |->
    (m_axis_tdata[15:0] == 16'h0000) &&
    (out_status == ST_OK || out_status == ST_LEN || out_status == ST_CRC))
    else $error("verdict word has bad payload fields or status");

  a_output_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

endmodule

bind crc16_frame_parser_unit crcfp_checker u_crcfp_checker (.*);
`default_nettype wire
